[hw/rtl/etfb_pkg.sv]
// ----------------------------------------------------------------------------
// etfb_pkg
// Shared types, codes and helpers of the Ethernet transmit frame builder.
// ----------------------------------------------------------------------------
package etfb_pkg;

  localparam int MIN_FRAME_BYTES = 64;   // payload + pad + FCS floor
  localparam int LEN_W           = 7;
  localparam int LEN_SAT         = 64;
  localparam int FCS_BYTES       = 4;
  localparam int PREAMBLE_LEN    = 7;    // 0x55 bytes before the delimiter
  localparam int CMD_DEPTH_DEF   = 2;
  localparam int OUT_DEPTH_DEF   = 2;

  localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
  localparam logic [7:0]  SFD_BYTE      = 8'hD5;
  localparam logic [7:0]  PAD_BYTE      = 8'h00;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

  // configuration register indexes
  localparam logic CFG_BYPASS     = 1'b0;
  localparam logic CFG_NO_PADDING = 1'b1;

  typedef enum logic [1:0] {
    KIND_PRE  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_PAD  = 2'd2,
    KIND_FCS  = 2'd3
  } kind_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  // request from the front to the back
  typedef struct packed {
    op_t        op;
    logic       raw;
    logic       nopad;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       frame_end;
  } out_t;

  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/etfb_fifo.sv]
// ----------------------------------------------------------------------------
// etfb_fifo
// Small register queue with a flag interface; head entry shown while not empty.
// ----------------------------------------------------------------------------
module etfb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

[hw/rtl/etfb_front.sv]
// ----------------------------------------------------------------------------
// etfb_front
// Holds configuration, tracks frame open/closed, turns input items into
// requests for the back end and drops data that arrives outside a frame.
// ----------------------------------------------------------------------------
module etfb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic          cfg_wdata,
  input  logic          accept,
  input  logic          in_func,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  output logic          cmd_we,
  output etfb_pkg::cmd_t cmd
);
  import etfb_pkg::*;

  logic bypass_r, bypass_nxt;
  logic no_padding_r, no_padding_nxt;
  logic in_frame_r, in_frame_nxt;

  always_comb begin
    bypass_nxt     = bypass_r;
    no_padding_nxt = no_padding_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BYPASS:     bypass_nxt     = cfg_wdata;
        CFG_NO_PADDING: no_padding_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.op     = op_t'(in_func);
    cmd.raw    = bypass_r;
    cmd.nopad  = no_padding_r;
    cmd.data   = in_data_byte;
    cmd.last   = in_last_byte;
    cmd_we       = 1'b0;
    in_frame_nxt = in_frame_r;
    if (accept) begin
      case (op_t'(in_func))
        OP_START: begin
          cmd_we       = 1'b1;
          in_frame_nxt = 1'b1;
        end
        OP_DATA: begin
          // drop data outside a frame
          cmd_we = in_frame_r;
          if (in_frame_r && in_last_byte) begin
            in_frame_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r     <= 1'b0;
      no_padding_r <= 1'b0;
      in_frame_r   <= 1'b0;
    end else begin
      bypass_r     <= bypass_nxt;
      no_padding_r <= no_padding_nxt;
      in_frame_r   <= in_frame_nxt;
    end
  end

endmodule

[hw/rtl/etfb_back.sv]
// ----------------------------------------------------------------------------
// etfb_back
// Byte sequencer: preamble, data with running CRC-32, padding and FCS (only
// data in bypass), one line byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module etfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  etfb_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  logic           out_full,
  output logic           out_we,
  output etfb_pkg::out_t out_item
);
  import etfb_pkg::*;

  typedef enum logic [1:0] {
    S_CMD,
    S_PRE,
    S_PAD,
    S_FCS
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  len_inc;
  logic              pad_more;
  logic              go;
  logic [31:0]       fcs;

  assign go       = !out_full;
  assign fcs      = ~crc_r;
  assign len_inc  = (len_r < LEN_W'(LEN_SAT)) ? len_r + 1'b1 : len_r;
  assign pad_more = (len_inc + LEN_W'(FCS_BYTES)) < LEN_W'(MIN_FRAME_BYTES);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    len_nxt   = len_r;
    cmd_pop   = 1'b0;
    out_we    = 1'b0;
    out_item  = '{data: PAD_BYTE, kind: KIND_PAD, frame_end: 1'b0};
    case (state_r)
      S_CMD: begin
        if (cmd_valid && go) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_START: begin
              crc_nxt = CRC_INIT;
              len_nxt = '0;
              if (!cmd.raw) begin
                out_we    = 1'b1;
                out_item  = '{data: PREAMBLE_BYTE, kind: KIND_PRE, frame_end: 1'b0};
                cnt_nxt   = 3'd1;
                state_nxt = S_PRE;
              end
            end
            OP_DATA: begin
              out_we   = 1'b1;
              out_item = '{data: cmd.data, kind: KIND_DATA,
                           frame_end: cmd.raw && cmd.last};
              len_nxt  = len_inc;
              if (!cmd.raw) begin
                crc_nxt = crc_fold(crc_r, cmd.data);
                if (cmd.last) begin
                  cnt_nxt   = '0;
                  state_nxt = (!cmd.nopad && pad_more) ? S_PAD : S_FCS;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PRE: begin
        if (go) begin
          out_we = 1'b1;
          if (cnt_r == 3'(PREAMBLE_LEN)) begin
            out_item  = '{data: SFD_BYTE, kind: KIND_PRE, frame_end: 1'b0};
            state_nxt = S_CMD;
          end else begin
            out_item = '{data: PREAMBLE_BYTE, kind: KIND_PRE, frame_end: 1'b0};
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
      end
      S_PAD: begin
        if (go) begin
          out_we  = 1'b1;
          crc_nxt = crc_fold(crc_r, PAD_BYTE);
          len_nxt = len_inc;
          if (!pad_more) begin
            cnt_nxt   = '0;
            state_nxt = S_FCS;
          end
        end
      end
      S_FCS: begin
        if (go) begin
          out_we        = 1'b1;
          out_item.kind = KIND_FCS;
          case (cnt_r[1:0])
            2'd0:    out_item.data = fcs[7:0];
            2'd1:    out_item.data = fcs[15:8];
            2'd2:    out_item.data = fcs[23:16];
            default: out_item.data = fcs[31:24];
          endcase
          // low byte first; the top byte closes the frame
          if (cnt_r == 3'(FCS_BYTES - 1)) begin
            out_item.frame_end = 1'b1;
            state_nxt          = S_CMD;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_CMD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CMD;
      cnt_r   <= '0;
      crc_r   <= CRC_INIT;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      len_r   <= len_nxt;
    end
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CMD) |-> !cmd_pop)
    else $error("request taken while a sequence is running");

  a_pad_needed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAD && out_we) |->
      ((len_r + LEN_W'(FCS_BYTES)) < LEN_W'(MIN_FRAME_BYTES)))
    else $error("padding past minimum frame size");

  a_fcs_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_we && out_item.kind == KIND_FCS && out_item.frame_end) |=> (state_r == S_CMD))
    else $error("sequencer not idle after FCS");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_we |-> !out_full)
    else $error("byte written into a full result queue");

endmodule

[hw/rtl/ethernet_tx_frame_builder.sv]
// ----------------------------------------------------------------------------
// ethernet_tx_frame_builder
// Ethernet transmit framing: preamble/SFD, payload, pad and CRC-32 FCS.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each item is a start (in_func = 0) or a data byte
// (in_func = 1, in_last_byte marks the final payload byte). Result channel:
// empty/pop; the oldest line byte sits on out_byte, out_byte_kind and
// out_frame_end while empty is low.
// Configuration: cfg_we with cfg_index (0 bypass, 1 no_padding) and
// cfg_wdata; write only while the block is idle.
// Throughput: one line byte per cycle while the result queue has room, set by
// the back-end byte sequencer. A data byte gives one line byte; a start
// gives the preamble and SFD (nothing in raw mode); outside raw mode a last byte
// adds pad bytes up to the minimum frame size unless no_padding, then the FCS.
// The front keeps accepting into a 2-entry request queue while the sequencer
// works. Items and line bytes are registered in the two queues.
// Reset: both queues empty, no frame open, configuration cleared, sequencer idle.
// A receiver that stops popping fills the result queue, which stalls the
// sequencer, then the request queue, and then raises full; nothing is lost.
// ----------------------------------------------------------------------------
module ethernet_tx_frame_builder #(
  parameter int CMD_DEPTH = etfb_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = etfb_pkg::OUT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic       in_func,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_byte_kind,
  output logic       out_frame_end
);
  import etfb_pkg::*;

  logic   accept;
  logic   cmd_we;
  cmd_t   cmd_in, cmd_head;
  logic   cmd_empty, cmd_pop;
  logic   out_we, out_full;
  out_t   out_in, out_head;

  assign accept = push && !full;

  etfb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .cmd_we       (cmd_we),
    .cmd          (cmd_in)
  );

  etfb_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_we),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  etfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_head),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_we    (out_we),
    .out_item  (out_in)
  );

  etfb_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_we),
    .wr_data (out_in),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_head),
    .empty   (empty)
  );

  assign out_byte      = out_head.data;
  assign out_byte_kind = out_head.kind;
  assign out_frame_end = out_head.frame_end;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Ethernet transmit frame builder. A queue-fed
// driver offers start and data requests with random gaps, a monitor pops line
// bytes with random stalls, and a local frame model predicts every preamble,
// data, pad and FCS byte across all bypass / no_padding settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etfb_pkg::*;

  typedef struct {
    op_t        op;
    logic [7:0] data;
    logic       last;
  } tx_req_t;

  typedef struct {
    logic [7:0] b;
    kind_t      kind;
    logic       fin;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_BYPASS;
  logic       cfg_wdata = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       in_func = OP_START;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_byte_kind;
  logic       out_frame_end;

  ethernet_tx_frame_builder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_byte_kind(out_byte_kind),
    .out_frame_end(out_frame_end)
  );

  always #6 clk = ~clk;

  tx_req_t    tx_req_q[$];
  line_byte_t line_q[$];
  int         err_cnt = 0;
  int         req_cnt = 0;
  bit         quiet = 1'b0;
  int         hold_req = 0;

  // frame model state
  logic        raw_m = 1'b0;
  logic        nopad_m = 1'b0;
  logic [31:0] crc_m = CRC_INIT;
  int          len_m = 0;
  logic        open_m = 1'b0;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[k];
      c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  task automatic emit(logic [7:0] b, kind_t kind, logic fin);
    line_byte_t lb;
    lb.b    = b;
    lb.kind = kind;
    lb.fin  = fin;
    line_q.push_back(lb);
  endtask

  task automatic count_len();
    if (len_m < LEN_SAT) len_m++;
  endtask

  // predict the line bytes caused by one accepted request
  task automatic frame_model(tx_req_t r);
    logic [31:0] fcs;
    if (r.op == OP_START) begin
      crc_m  = CRC_INIT;
      len_m  = 0;
      open_m = 1'b1;
      if (!raw_m) begin
        for (int i = 0; i < PREAMBLE_LEN; i++) emit(PREAMBLE_BYTE, KIND_PRE, 1'b0);
        emit(SFD_BYTE, KIND_PRE, 1'b0);
      end
    end else if (open_m) begin
      if (raw_m) begin
        emit(r.data, KIND_DATA, r.last);
        count_len();
        if (r.last) open_m = 1'b0;
      end else begin
        emit(r.data, KIND_DATA, 1'b0);
        crc_m = crc_step(crc_m, r.data);
        count_len();
        if (r.last) begin
          if (!nopad_m) begin
            while (len_m + FCS_BYTES < MIN_FRAME_BYTES) begin
              emit(PAD_BYTE, KIND_PAD, 1'b0);
              crc_m = crc_step(crc_m, PAD_BYTE);
              count_len();
            end
          end
          fcs = ~crc_m;
          for (int i = 0; i < FCS_BYTES; i++)
            emit(fcs[8*i +: 8], KIND_FCS, i == FCS_BYTES - 1);
          open_m = 1'b0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  int   gap_left = 0;
  bit   tx_calm = 1'b0;
  logic drive_n;

  always @(posedge clk) begin
    if (!rst_n) begin
      push         <= 1'b0;
      in_func      <= OP_START;
      in_data_byte <= 8'h00;
      in_last_byte <= 1'b0;
    end else begin
      if (push && !full) begin
        frame_model(tx_req_q[0]);
        void'(tx_req_q.pop_front());
        drive_n = 1'b0;
      end
      if ($urandom_range(49) == 0) tx_calm = !tx_calm;
      if (push && full) begin
        drive_n = 1'b1;  // hold the blocked request
      end else if (gap_left > 0) begin
        gap_left--;
        drive_n = 1'b0;
      end else if (tx_req_q.size() == 0) begin
        drive_n = 1'b0;
      end else if (!quiet && !tx_calm && $urandom_range(7) == 0) begin
        gap_left = $urandom_range(19, 1) - 1;
        drive_n  = 1'b0;
      end else begin
        drive_n = 1'b1;
      end
      push <= drive_n;
      if (drive_n) begin
        in_func      <= tx_req_q[0].op;
        in_data_byte <= tx_req_q[0].data;
        in_last_byte <= tx_req_q[0].last;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int         stall_left = 0;
  int         hold_left = 0;
  int         hold_seen = 0;
  bit         rx_calm = 1'b0;
  logic       pop_n;
  line_byte_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (line_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected byte: expected none, actual %h kind %0d end %0b",
                   $time, out_byte, out_byte_kind, out_frame_end);
        end else begin
          want = line_q.pop_front();
          if (out_byte !== want.b || out_byte_kind !== want.kind ||
              out_frame_end !== want.fin) begin
            err_cnt++;
            $display("%0t: mismatch: expected %h kind %0d end %0b, actual %h kind %0d end %0b",
                     $time, want.b, want.kind, want.fin,
                     out_byte, out_byte_kind, out_frame_end);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if ($urandom_range(49) == 0) rx_calm = !rx_calm;
      if (hold_left > 0) begin
        hold_left--;
        pop_n = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop_n = 1'b0;
      end else if (!quiet && !rx_calm && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(19, 1) - 1;
        pop_n      = 1'b0;
      end else begin
        pop_n = 1'b1;
      end
      pop <= pop_n;
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic queue_req(op_t op, logic [7:0] d, logic l);
    tx_req_t r;
    r.op   = op;
    r.data = d;
    r.last = l;
    tx_req_q.push_back(r);
    req_cnt++;
  endtask

  task automatic queue_frame(int n_bytes);
    queue_req(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
    for (int i = 0; i < n_bytes; i++)
      queue_req(OP_DATA, 8'($urandom_range(255)), i == n_bytes - 1);
  endtask

  // mostly well-formed frames, some abandoned frames and stray requests
  task automatic queue_random(int n_req);
    int stop;
    int r;
    stop = req_cnt + n_req;
    while (req_cnt < stop) begin
      r = $urandom_range(99);
      if (r < 70) begin
        queue_frame($urandom_range(16, 1));
      end else if (r < 80) begin
        queue_frame($urandom_range(70, 56));
      end else if (r < 88) begin
        queue_frame($urandom_range(4, 0) + 0);
        queue_req(OP_DATA, 8'($urandom_range(255)), 1'b0);
      end else begin
        queue_req(op_t'($urandom_range(1)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  task automatic drain();
    while (tx_req_q.size() != 0 || push || line_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BYPASS) raw_m = val;
    else nopad_m = val;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // padded frames: stray data, ignored start fields, abandon, short frame
    queue_req(OP_DATA, 8'hFF, 1'b1);
    queue_req(OP_START, 8'hFF, 1'b1);
    queue_req(OP_DATA, 8'h00, 1'b0);
    queue_req(OP_DATA, 8'hFF, 1'b0);
    queue_req(OP_DATA, 8'h5A, 1'b1);
    queue_req(OP_START, 8'h00, 1'b0);
    queue_req(OP_DATA, 8'h12, 1'b0);
    queue_req(OP_START, 8'hA5, 1'b0);
    queue_req(OP_DATA, 8'hFF, 1'b1);
    queue_random(90);
    hold_req++;  // stall the receiver long enough to back up the input
    drain();

    write_reg(CFG_NO_PADDING, 1'b1);
    queue_req(OP_START, 8'h00, 1'b0);
    queue_req(OP_DATA, 8'hAB, 1'b1);
    queue_random(50);
    drain();  // sender pauses until every byte is out
    queue_random(50);
    drain();

    write_reg(CFG_BYPASS, 1'b1);
    write_reg(CFG_NO_PADDING, 1'b0);
    queue_req(OP_START, 8'hFF, 1'b1);
    queue_req(OP_DATA, 8'h00, 1'b0);
    queue_req(OP_DATA, 8'hFF, 1'b1);
    queue_req(OP_DATA, 8'h33, 1'b1);
    queue_random(100);
    drain();

    write_reg(CFG_NO_PADDING, 1'b1);
    queue_random(100);
    drain();

    write_reg(CFG_BYPASS, 1'b0);
    write_reg(CFG_NO_PADDING, 1'b0);
    quiet = 1'b1;
    queue_random(100);
    drain();

    if (err_cnt == 0 && line_q.size() == 0) begin
      $display("ethernet_tx_frame_builder verification clean");
    end else begin
      $display("ethernet_tx_frame_builder verification failed");
    end
    $finish;
  end

  initial begin
    #36_000_000;
    $display("ethernet_tx_frame_builder verification failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/etfb_pkg.sv
hw/rtl/etfb_fifo.sv
hw/rtl/etfb_front.sv
hw/rtl/etfb_back.sv
hw/rtl/ethernet_tx_frame_builder.sv
sim/tb.sv
